[hdl/htw_pkg.sv]
// Shared operation and status codes for the hashed timer wheel.
package htw_pkg;

	typedef enum logic [2:0] {
		MODE_TICK   = 3'd0,
		MODE_CREATE = 3'd1,
		MODE_START  = 3'd2,
		MODE_STOP   = 3'd3,
		MODE_RESET  = 3'd4,
		MODE_CHANGE = 3'd5,
		MODE_DELETE = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_INVALID = 2'd1,
		STATUS_NOFREE  = 2'd2
	} status_t;

	localparam int unsigned ID_OUT_W = 4;

endpackage

[hdl/htw_div.sv]
// Splits a period by the wheel size, a power of two, into rounds and slot offset with a shift and a mask.
module htw_div #(
	parameter int unsigned PERIOD_BITS = 32,
	parameter int unsigned WHEEL_SLOTS = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [PERIOD_BITS-1:0]         dividend,
	output logic                           done,
	output logic [PERIOD_BITS-1:0]         quotient,
	output logic [$clog2(WHEEL_SLOTS)-1:0] remainder
);

	localparam int unsigned SLOT_W = $clog2(WHEEL_SLOTS);

	logic                   done_q;
	logic [PERIOD_BITS-1:0] quo_q;
	logic [SLOT_W-1:0]      rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	// The result is held until the next start so the sequencer can still use it after done has dropped.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend >> SLOT_W;
			rem_q <= SLOT_W'(dividend);
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

[hdl/htw_mem.sv]
// Timer record memory: one write port, one read port with registered read data.
module htw_mem #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hdl/hashed_timer_wheel_top.sv]
// Hashed timer wheel: TIMERS timer records in one memory, walked by a sequencer.
// A tick reads the records one per cycle while the output register is free; the next beat
// is taken only once its last beat has been registered. Every operation ends in an answer
// beat before the next beat is taken, and a full output register stalls the walk and every
// answer. WHEEL_SLOTS is a power of two. Reset clears the used and armed flags and the
// cursor at once.
module hashed_timer_wheel_top #(
	parameter int unsigned TIMERS      = 16,
	parameter int unsigned WHEEL_SLOTS = 256,
	parameter int unsigned PERIOD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // timer_id[3:0], period[35:4], periodic[36], zero fill
	input  logic [2:0]  s_tuser,  // mode[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // status[1:0], result_id[5:2], zero fill
	output logic [0:0]  m_tuser,  // expired[0]
	output logic        m_tlast
);

	localparam int unsigned ID_W   = $clog2(TIMERS);
	localparam int unsigned CNT_W  = $clog2(TIMERS + 1);
	localparam int unsigned SLOT_W = $clog2(WHEEL_SLOTS);
	localparam int unsigned PB     = PERIOD_BITS;
	localparam int unsigned RL_LO  = 0;
	localparam int unsigned SL_LO  = PB;
	localparam int unsigned RI_LO  = PB + SLOT_W;
	localparam int unsigned OF_LO  = 2 * PB + SLOT_W;
	localparam int unsigned RE_POS = 2 * PB + 2 * SLOT_W;
	localparam int unsigned REC_W  = 2 * PB + 2 * SLOT_W + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN,
		ST_CSCAN,
		ST_DIV,
		ST_RD,
		ST_MOD,
		ST_RESP
	} state_t;

	function automatic logic [SLOT_W-1:0] arm_slot(input logic [SLOT_W-1:0] cur,
	                                               input logic [SLOT_W-1:0] off);
		logic [SLOT_W:0] sum;
		sum = {1'b0, cur} + {1'b0, off};
		if (sum >= (SLOT_W + 1)'(WHEEL_SLOTS)) begin
			sum = sum - (SLOT_W + 1)'(WHEEL_SLOTS);
		end
		return sum[SLOT_W-1:0];
	endfunction

	state_t                    state_q;
	htw_pkg::mode_t            mode_q;
	logic [ID_W-1:0]           tid_q;
	logic [PB-1:0]             per_q;
	logic                      periodic_q;
	logic [SLOT_W-1:0]         cursor_q;
	logic [TIMERS-1:0]         in_use_q;
	logic [TIMERS-1:0]         armed_q;
	logic [CNT_W-1:0]          issue_q;
	logic                      valid_s1;
	logic [ID_W-1:0]           idx_s1;
	logic                      pend_v_q;
	logic [ID_W-1:0]           pend_id_q;
	logic [ID_W-1:0]           free_q;
	htw_pkg::status_t          res_status_q;
	logic [3:0]                res_id_q;
	logic                      div_start_q;
	logic [PB-1:0]             dvd_q;
	logic                      m_valid_q;
	htw_pkg::status_t          m_status_q;
	logic [3:0]                m_id_q;
	logic                      m_exp_q;
	logic                      m_last_q;

	htw_pkg::mode_t            in_mode;
	logic [6:0]                in_id7;
	logic [ID_W-1:0]           in_tid;
	logic                      in_valid;
	logic [63:0]               in_pwide;
	logic [PB-1:0]             in_per;
	logic [SLOT_W-1:0]         cursor_next;
	logic                      out_free;

	logic                      div_done;
	logic [PB-1:0]             div_quo;
	logic [SLOT_W-1:0]         div_rem;
	logic [SLOT_W:0]           rem_inc;
	logic [SLOT_W-1:0]         new_off;

	logic                      mem_we;
	logic [ID_W-1:0]           wr_addr;
	logic                      rd_en;
	logic [ID_W-1:0]           rd_addr;
	logic [REC_W-1:0]          wr_data;
	logic [REC_W-1:0]          rd_data;

	logic                      e_reload;
	logic [SLOT_W-1:0]         e_off;
	logic [PB-1:0]             e_rinit;
	logic [SLOT_W-1:0]         e_slot;
	logic [PB-1:0]             e_rleft;
	logic                      w_reload;
	logic [SLOT_W-1:0]         w_off;
	logic [PB-1:0]             w_rinit;
	logic [SLOT_W-1:0]         w_slot;
	logic [PB-1:0]             w_rleft;

	logic                      s1_match;
	logic                      s1_zero;
	logic                      s1_hit;

	assign in_mode   = htw_pkg::mode_t'(s_tuser);
	assign in_id7    = {3'b000, s_tdata[3:0]};
	assign in_tid    = in_id7[ID_W-1:0];
	assign in_valid  = (in_id7 < 7'(TIMERS)) && in_use_q[in_tid];
	assign in_pwide  = {32'd0, s_tdata[35:4]};
	assign in_per    = in_pwide[PB-1:0];
	assign cursor_next = (cursor_q == SLOT_W'(WHEEL_SLOTS - 1)) ? '0 : cursor_q + 1'b1;
	assign out_free  = !m_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE);

	// The divider works on p - 1, so the slot offset p mod WHEEL_SLOTS is the remainder plus one.
	assign rem_inc = {1'b0, div_rem} + 1'b1;
	assign new_off = (rem_inc == (SLOT_W + 1)'(WHEEL_SLOTS)) ? '0 : rem_inc[SLOT_W-1:0];

	assign e_rleft  = rd_data[RL_LO +: PB];
	assign e_slot   = rd_data[SL_LO +: SLOT_W];
	assign e_rinit  = rd_data[RI_LO +: PB];
	assign e_off    = rd_data[OF_LO +: SLOT_W];
	assign e_reload = rd_data[RE_POS];
	assign wr_data  = {w_reload, w_off, w_rinit, w_slot, w_rleft};

	assign s1_match = valid_s1 && armed_q[idx_s1] && (e_slot == cursor_q);
	assign s1_zero  = (e_rleft == '0);
	assign s1_hit   = s1_match && s1_zero;

	htw_div #(
		.PERIOD_BITS(PB),
		.WHEEL_SLOTS(WHEEL_SLOTS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (dvd_q),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	htw_mem #(
		.DEPTH(TIMERS),
		.WIDTH(REC_W)
	) u_mem (
		.clk    (clk),
		.wr_en  (mem_we),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		mem_we   = 1'b0;
		wr_addr  = tid_q;
		rd_en    = 1'b0;
		rd_addr  = tid_q;
		w_reload = e_reload;
		w_off    = e_off;
		w_rinit  = e_rinit;
		w_slot   = e_slot;
		w_rleft  = e_rleft;
		case (state_q)
			ST_SCAN: begin
				// While stalled the record in flight is read again so its data stays put.
				if (out_free) begin
					rd_en   = issue_q < CNT_W'(TIMERS);
					rd_addr = issue_q[ID_W-1:0];
				end else begin
					rd_en   = 1'b1;
					rd_addr = idx_s1;
				end
				wr_addr = idx_s1;
				if (out_free && s1_match && (!s1_zero || e_reload)) begin
					mem_we = 1'b1;
					if (s1_zero) begin
						w_slot  = arm_slot(cursor_q, e_off);
						w_rleft = e_rinit;
					end else begin
						w_rleft = e_rleft - 1'b1;
					end
				end
			end
			ST_DIV: begin
				if (div_done && mode_q == htw_pkg::MODE_CREATE) begin
					mem_we   = 1'b1;
					wr_addr  = free_q;
					w_reload = periodic_q;
					w_off    = new_off;
					w_rinit  = div_quo;
					w_slot   = '0;
					w_rleft  = '0;
				end
			end
			ST_RD: begin
				rd_en = 1'b1;
			end
			ST_MOD: begin
				mem_we = 1'b1;
				if (mode_q == htw_pkg::MODE_CHANGE) begin
					w_off   = new_off;
					w_rinit = div_quo;
					if (armed_q[tid_q]) begin
						w_slot  = arm_slot(cursor_q, new_off);
						w_rleft = div_quo;
					end
				end else begin
					w_slot  = arm_slot(cursor_q, e_off);
					w_rleft = e_rinit;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mode_q       <= htw_pkg::MODE_TICK;
			tid_q        <= '0;
			per_q        <= '0;
			periodic_q   <= 1'b0;
			cursor_q     <= '0;
			in_use_q     <= '0;
			armed_q      <= '0;
			issue_q      <= '0;
			valid_s1     <= 1'b0;
			idx_s1       <= '0;
			pend_v_q     <= 1'b0;
			pend_id_q    <= '0;
			free_q       <= '0;
			res_status_q <= htw_pkg::STATUS_OK;
			res_id_q     <= '0;
			div_start_q  <= 1'b0;
			dvd_q        <= '0;
			m_valid_q    <= 1'b0;
			m_status_q   <= htw_pkg::STATUS_OK;
			m_id_q       <= '0;
			m_exp_q      <= 1'b0;
			m_last_q     <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						mode_q       <= in_mode;
						tid_q        <= in_tid;
						per_q        <= in_per;
						periodic_q   <= s_tdata[36];
						res_id_q     <= '0;
						res_status_q <= htw_pkg::STATUS_INVALID;
						state_q      <= ST_RESP;
						case (in_mode)
							htw_pkg::MODE_TICK: begin
								cursor_q <= cursor_next;
								issue_q  <= '0;
								valid_s1 <= 1'b0;
								pend_v_q <= 1'b0;
								state_q  <= ST_SCAN;
							end
							htw_pkg::MODE_CREATE: begin
								issue_q <= '0;
								state_q <= ST_CSCAN;
							end
							htw_pkg::MODE_START, htw_pkg::MODE_RESET: begin
								if (in_valid) begin
									state_q <= ST_RD;
								end
							end
							htw_pkg::MODE_STOP: begin
								if (in_valid) begin
									armed_q[in_tid] <= 1'b0;
									res_status_q    <= htw_pkg::STATUS_OK;
								end
							end
							htw_pkg::MODE_DELETE: begin
								if (in_valid) begin
									armed_q[in_tid]  <= 1'b0;
									in_use_q[in_tid] <= 1'b0;
									res_status_q     <= htw_pkg::STATUS_OK;
								end
							end
							htw_pkg::MODE_CHANGE: begin
								if (in_valid && in_per != '0) begin
									dvd_q       <= in_per - 1'b1;
									div_start_q <= 1'b1;
									state_q     <= ST_DIV;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (out_free) begin
						if (!valid_s1 && issue_q == CNT_W'(TIMERS)) begin
							state_q <= ST_FIN;
						end else begin
							if (issue_q < CNT_W'(TIMERS)) begin
								valid_s1 <= 1'b1;
								idx_s1   <= issue_q[ID_W-1:0];
								issue_q  <= issue_q + 1'b1;
							end else begin
								valid_s1 <= 1'b0;
							end
							// A hit is held back one step so the final expiry can carry tlast.
							if (s1_hit) begin
								if (!e_reload) begin
									armed_q[idx_s1] <= 1'b0;
								end
								if (pend_v_q) begin
									m_valid_q  <= 1'b1;
									m_status_q <= htw_pkg::STATUS_OK;
									m_id_q     <= 4'(pend_id_q);
									m_exp_q    <= 1'b1;
									m_last_q   <= 1'b0;
								end
								pend_v_q  <= 1'b1;
								pend_id_q <= idx_s1;
							end
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						m_valid_q  <= 1'b1;
						m_status_q <= htw_pkg::STATUS_OK;
						m_id_q     <= pend_v_q ? 4'(pend_id_q) : 4'd0;
						m_exp_q    <= pend_v_q;
						m_last_q   <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				ST_CSCAN: begin
					if (!in_use_q[issue_q[ID_W-1:0]]) begin
						free_q      <= issue_q[ID_W-1:0];
						dvd_q       <= (per_q == '0) ? '0 : per_q - 1'b1;
						div_start_q <= 1'b1;
						state_q     <= ST_DIV;
					end else if (issue_q == CNT_W'(TIMERS - 1)) begin
						res_status_q <= htw_pkg::STATUS_NOFREE;
						state_q      <= ST_RESP;
					end else begin
						issue_q <= issue_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if (mode_q == htw_pkg::MODE_CREATE) begin
							in_use_q[free_q] <= 1'b1;
							armed_q[free_q]  <= 1'b0;
							res_status_q     <= htw_pkg::STATUS_OK;
							res_id_q         <= 4'(free_q);
							state_q          <= ST_RESP;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					if (mode_q != htw_pkg::MODE_CHANGE) begin
						armed_q[tid_q] <= 1'b1;
					end
					res_status_q <= htw_pkg::STATUS_OK;
					state_q      <= ST_RESP;
				end
				ST_RESP: begin
					if (out_free) begin
						m_valid_q  <= 1'b1;
						m_status_q <= res_status_q;
						m_id_q     <= res_id_q;
						m_exp_q    <= 1'b0;
						m_last_q   <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = {2'b00, m_id_q, m_status_q};
	assign m_tuser[0] = m_exp_q;
	assign m_tlast    = m_last_q;

	a_armed_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		(armed_q & ~in_use_q) == '0)
		else $error("armed timer is not in use");

	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_scan_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && mem_we && rd_en) |-> wr_addr != rd_addr)
		else $error("walk writes the record it is reading");

	a_expiry_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_exp_q) |-> m_status_q == htw_pkg::STATUS_OK)
		else $error("expiry beat without ok status");

	a_slots_pow2: assert property (@(posedge clk)
		(WHEEL_SLOTS & (WHEEL_SLOTS - 1)) == 0)
		else $error("wheel size is not a power of two");

endmodule
